// ===== sv/fmlf_pkg.sv =====
`default_nettype none
package fmlf_pkg;

  localparam int unsigned PRICE_W   = 16;
  localparam int unsigned FRAC_W    = 8;
  localparam int unsigned OUT_SLOTS = 5;
  localparam int unsigned VALID_W   = 3;
  localparam int unsigned QCOUNT_W  = 13;
  localparam int unsigned DIV_STEPS = PRICE_W + FRAC_W;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);
  localparam int unsigned MEAN_W    = PRICE_W + FRAC_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIVIDE,
    ST_WAIT_OUT
  } state_e;

  typedef struct packed {
    logic accept;
    logic div_load;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_last;
  } status_t;

endpackage
`default_nettype wire

// ===== sv/fmlf_ord_if.sv =====
`default_nettype none
interface fmlf_ord_if;
  logic                          valid;
  logic                          ready;
  logic [fmlf_pkg::PRICE_W-1:0]  price;
  logic                          seller_online;
  logic                          is_sell_order;
  logic                          last_order;

  modport source (
    output valid, price, seller_online, is_sell_order, last_order,
    input  ready
  );
  modport sink (
    input  valid, price, seller_online, is_sell_order, last_order,
    output ready
  );
endinterface
`default_nettype wire

// ===== sv/fmlf_res_if.sv =====
`default_nettype none
interface fmlf_res_if;
  logic                           valid;
  logic                           ready;
  logic [fmlf_pkg::PRICE_W-1:0]   mean_whole;
  logic [fmlf_pkg::FRAC_W-1:0]    mean_fraction;
  logic [fmlf_pkg::PRICE_W-1:0]   lowest_first;
  logic [fmlf_pkg::PRICE_W-1:0]   lowest_second;
  logic [fmlf_pkg::PRICE_W-1:0]   lowest_third;
  logic [fmlf_pkg::PRICE_W-1:0]   lowest_fourth;
  logic [fmlf_pkg::PRICE_W-1:0]   lowest_fifth;
  logic [fmlf_pkg::VALID_W-1:0]   lowest_valid;
  logic [fmlf_pkg::QCOUNT_W-1:0]  qualifying_count;

  modport source (
    output valid, mean_whole, mean_fraction, lowest_first, lowest_second,
           lowest_third, lowest_fourth, lowest_fifth, lowest_valid,
           qualifying_count,
    input  ready
  );
  modport sink (
    input  valid, mean_whole, mean_fraction, lowest_first, lowest_second,
           lowest_third, lowest_fourth, lowest_fifth, lowest_valid,
           qualifying_count,
    output ready
  );
endinterface
`default_nettype wire

// ===== sv/filtered_mean_and_lowest_five_core.sv =====
`default_nettype none
// Reads a list of orders, one item per cycle while ready, and counts those
// that are both seller_online and is_sell_order. At the item that carries
// last_order it returns one result: the mean qualifying price as unsigned
// 16.8 fixed point (truncated), the five lowest qualifying prices in
// ascending order (unused slots 0), the number of real slots, and the
// qualifying count, which with the sum stops growing at MAX_ORDERS. An empty
// list returns all zeros. After a last_order item the input stays not ready
// while the block loads the divider, runs the bit-serial restoring divider
// that forms the mean one quotient bit per cycle, and loads the result
// register; it waits longer only while a previous result is still held there.
// KEEP_LOWEST sizes the kept set.
module filtered_mean_and_lowest_five_core #(
  parameter int unsigned KEEP_LOWEST = 5,
  parameter int unsigned MAX_ORDERS  = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  fmlf_ord_if.sink         ord_i,
  fmlf_res_if.source       res_o
);

  fmlf_pkg::cmd_t    cmd;
  fmlf_pkg::status_t status;
  logic [fmlf_pkg::PRICE_W-1:0] slot [fmlf_pkg::OUT_SLOTS];

  fmlf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ord_valid_i (ord_i.valid),
    .ord_last_i  (ord_i.last_order),
    .ord_ready_o (ord_i.ready),
    .res_ready_i (res_o.ready),
    .res_valid_o (res_o.valid),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  fmlf_dpath #(
    .KEEP_LOWEST (KEEP_LOWEST),
    .MAX_ORDERS  (MAX_ORDERS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .price_i         (ord_i.price),
    .qual_i          (ord_i.seller_online && ord_i.is_sell_order),
    .mean_whole_o    (res_o.mean_whole),
    .mean_fraction_o (res_o.mean_fraction),
    .slot_o          (slot),
    .lowest_valid_o  (res_o.lowest_valid),
    .qcount_o        (res_o.qualifying_count)
  );

  assign res_o.lowest_first  = slot[0];
  assign res_o.lowest_second = slot[1];
  assign res_o.lowest_third  = slot[2];
  assign res_o.lowest_fourth = slot[3];
  assign res_o.lowest_fifth  = slot[4];

  a_last_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ord_i.valid && ord_i.ready && ord_i.last_order |=> !ord_i.ready)
    else $error("input ready right after a last item");

  a_ascending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.lowest_valid >= 3'd2 |->
      res_o.lowest_second >= res_o.lowest_first)
    else $error("kept prices out of order");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.lowest_valid == 3'd0 |->
      res_o.qualifying_count == 13'd0 && res_o.mean_whole == 16'd0 &&
      res_o.mean_fraction == 8'd0)
    else $error("empty list gave nonzero result");

endmodule
`default_nettype wire

// ===== sv/fmlf_ctrl.sv =====
`default_nettype none
module fmlf_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              ord_valid_i,
  input  wire logic              ord_last_i,
  output logic                   ord_ready_o,
  input  wire logic              res_ready_i,
  output logic                   res_valid_o,
  input  wire fmlf_pkg::status_t status_i,
  output fmlf_pkg::cmd_t         cmd_o
);

  fmlf_pkg::state_e state_q, state_d;
  logic             res_valid_q, res_valid_d;
  logic             out_free;

  assign out_free = !res_valid_q || res_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fmlf_pkg::ST_IDLE: begin
        if (ord_valid_i && ord_last_i) state_d = fmlf_pkg::ST_LOAD;
      end
      fmlf_pkg::ST_LOAD: begin
        state_d = fmlf_pkg::ST_DIVIDE;
      end
      fmlf_pkg::ST_DIVIDE: begin
        if (status_i.div_last) state_d = fmlf_pkg::ST_WAIT_OUT;
      end
      fmlf_pkg::ST_WAIT_OUT: begin
        if (out_free) state_d = fmlf_pkg::ST_IDLE;
      end
      default: state_d = fmlf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    ord_ready_o = 1'b0;
    unique case (state_q)
      fmlf_pkg::ST_IDLE: begin
        ord_ready_o  = 1'b1;
        cmd_o.accept = ord_valid_i;
      end
      fmlf_pkg::ST_LOAD:     cmd_o.div_load = 1'b1;
      fmlf_pkg::ST_DIVIDE:   cmd_o.div_step = 1'b1;
      fmlf_pkg::ST_WAIT_OUT: cmd_o.out_load = out_free;
      default: ;
    endcase
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (cmd_o.out_load) begin
      res_valid_d = 1'b1;
    end else if (res_ready_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fmlf_pkg::ST_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

  assign res_valid_o = res_valid_q;

endmodule
`default_nettype wire

// ===== sv/fmlf_dpath.sv =====
`default_nettype none
module fmlf_dpath #(
  parameter int unsigned KEEP_LOWEST = 5,
  parameter int unsigned MAX_ORDERS  = 4096
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire fmlf_pkg::cmd_t                cmd_i,
  output fmlf_pkg::status_t                  status_o,
  input  wire logic [fmlf_pkg::PRICE_W-1:0]  price_i,
  input  wire logic                          qual_i,
  output logic [fmlf_pkg::PRICE_W-1:0]       mean_whole_o,
  output logic [fmlf_pkg::FRAC_W-1:0]        mean_fraction_o,
  output logic [fmlf_pkg::PRICE_W-1:0]       slot_o [fmlf_pkg::OUT_SLOTS],
  output logic [fmlf_pkg::VALID_W-1:0]       lowest_valid_o,
  output logic [fmlf_pkg::QCOUNT_W-1:0]      qcount_o
);

  localparam int unsigned CNT_W  = $clog2(MAX_ORDERS + 1);
  localparam int unsigned SUM_W  = fmlf_pkg::PRICE_W + CNT_W;
  localparam int unsigned KC_W   = $clog2(KEEP_LOWEST + 1);
  localparam int unsigned PW     = fmlf_pkg::PRICE_W;
  localparam int unsigned MW     = fmlf_pkg::MEAN_W;
  localparam int unsigned SW     = fmlf_pkg::STEP_W;
  localparam int unsigned KCX_W  = KC_W + fmlf_pkg::VALID_W;
  localparam int unsigned QX_W   = CNT_W + fmlf_pkg::QCOUNT_W;

  // accumulators
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [PW-1:0]    kept_q [KEEP_LOWEST];
  logic [PW-1:0]    kept_d [KEEP_LOWEST];
  logic [KC_W-1:0]  kcnt_q, kcnt_d;
  logic [KEEP_LOWEST-1:0] gt;
  logic             kfull;
  logic             cnt_open;

  assign kfull    = kcnt_q == KC_W'(KEEP_LOWEST);
  assign cnt_open = cnt_q < CNT_W'(MAX_ORDERS);

  always_comb begin
    for (int i = 0; i < KEEP_LOWEST; i++) begin
      gt[i] = (KC_W'(i) < kcnt_q) && (kept_q[i] > price_i);
    end
  end

  always_comb begin
    for (int i = 0; i < KEEP_LOWEST; i++) begin
      kept_d[i] = kept_q[i];
      if (gt[i] || (!kfull && KC_W'(i) == kcnt_q)) begin
        if (i == 0) begin
          kept_d[i] = price_i;
        end else if (gt[i-1]) begin
          kept_d[i] = kept_q[i-1];
        end else begin
          kept_d[i] = price_i;
        end
      end
    end
  end

  always_comb begin
    sum_d  = sum_q;
    cnt_d  = cnt_q;
    kcnt_d = kcnt_q;
    if (cmd_i.out_load) begin
      sum_d  = '0;
      cnt_d  = '0;
      kcnt_d = '0;
    end else if (cmd_i.accept && qual_i) begin
      if (cnt_open) begin
        sum_d = sum_q + SUM_W'(price_i);
        cnt_d = cnt_q + CNT_W'(1);
      end
      if (!kfull) kcnt_d = kcnt_q + KC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      cnt_q  <= '0;
      kcnt_q <= '0;
    end else begin
      sum_q  <= sum_d;
      cnt_q  <= cnt_d;
      kcnt_q <= kcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && qual_i) begin
      for (int i = 0; i < KEEP_LOWEST; i++) kept_q[i] <= kept_d[i];
    end
  end

  // restoring divider, one quotient bit per cycle; sum >> 16 < count,
  // so the upper quotient bits are zero and the remainder starts there
  logic [CNT_W-1:0] rem_q, rem_d;
  logic [MW-1:0]    quo_q, quo_d;
  logic [SW-1:0]    step_q, step_d;
  logic [CNT_W:0]   trial;
  logic [CNT_W:0]   trial_sub;
  logic             ge;

  assign trial     = {rem_q, quo_q[MW-1]};
  assign ge        = trial >= {1'b0, cnt_q};
  assign trial_sub = trial - {1'b0, cnt_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    step_d = step_q;
    if (cmd_i.div_load) begin
      rem_d  = sum_q[SUM_W-1:PW];
      quo_d  = {sum_q[PW-1:0], {fmlf_pkg::FRAC_W{1'b0}}};
      step_d = '0;
    end else if (cmd_i.div_step) begin
      rem_d  = ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
      quo_d  = {quo_q[MW-2:0], ge};
      step_d = step_q + SW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else begin
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign status_o.div_last = step_q == SW'(fmlf_pkg::DIV_STEPS - 1);

  // result register
  logic [KCX_W-1:0]                  kc_ext;
  logic [fmlf_pkg::VALID_W-1:0]      nvalid;
  logic [QX_W-1:0]                   cnt_ext;
  logic [MW-1:0]                     mean;
  logic [PW-1:0]                     slot_d [fmlf_pkg::OUT_SLOTS];
  logic [PW-1:0]                     slot_q [fmlf_pkg::OUT_SLOTS];
  logic [MW-1:0]                     mean_q;
  logic [fmlf_pkg::VALID_W-1:0]      valid_q;
  logic [fmlf_pkg::QCOUNT_W-1:0]     qcount_q;

  assign kc_ext  = KCX_W'(kcnt_q);
  assign nvalid  = (kc_ext > KCX_W'(fmlf_pkg::OUT_SLOTS)) ?
                   fmlf_pkg::VALID_W'(fmlf_pkg::OUT_SLOTS) :
                   kc_ext[fmlf_pkg::VALID_W-1:0];
  assign cnt_ext = QX_W'(cnt_q);
  assign mean    = (cnt_q == '0) ? '0 : quo_q;

  for (genvar s = 0; s < fmlf_pkg::OUT_SLOTS; s++) begin : g_slot
    if (s < KEEP_LOWEST) begin : g_kept
      assign slot_d[s] = (fmlf_pkg::VALID_W'(s) < nvalid) ? kept_q[s] : '0;
    end else begin : g_zero
      assign slot_d[s] = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      slot_q   <= slot_d;
      mean_q   <= mean;
      valid_q  <= nvalid;
      qcount_q <= cnt_ext[fmlf_pkg::QCOUNT_W-1:0];
    end
  end

  assign slot_o          = slot_q;
  assign mean_whole_o    = mean_q[MW-1:fmlf_pkg::FRAC_W];
  assign mean_fraction_o = mean_q[fmlf_pkg::FRAC_W-1:0];
  assign lowest_valid_o  = valid_q;
  assign qcount_o        = qcount_q;

endmodule
`default_nettype wire

// ===== tb/tb_filtered_mean_and_lowest_five_core.sv =====
`timescale 1ns / 1ps

module tb_filtered_mean_and_lowest_five_core;

  localparam int unsigned KEEP       = 5;
  localparam int unsigned MAX_ORDERS = 4096;
  localparam int unsigned RAND_ITEMS = 730;
  localparam int unsigned HOLD_LEN   = 400;

  typedef struct packed {
    logic [fmlf_pkg::PRICE_W-1:0] price;
    logic                         seller_online;
    logic                         is_sell_order;
    logic                         last_order;
  } order_t;

  typedef struct packed {
    logic [fmlf_pkg::PRICE_W-1:0]  mean_whole;
    logic [fmlf_pkg::FRAC_W-1:0]   mean_fraction;
    logic [fmlf_pkg::PRICE_W-1:0]  lowest_first;
    logic [fmlf_pkg::PRICE_W-1:0]  lowest_second;
    logic [fmlf_pkg::PRICE_W-1:0]  lowest_third;
    logic [fmlf_pkg::PRICE_W-1:0]  lowest_fourth;
    logic [fmlf_pkg::PRICE_W-1:0]  lowest_fifth;
    logic [fmlf_pkg::VALID_W-1:0]  lowest_valid;
    logic [fmlf_pkg::QCOUNT_W-1:0] qualifying_count;
  } summary_t;

  typedef struct {
    order_t   ord;
    bit       typed;
    summary_t summary;
  } plan_row_t;

  logic clk;
  logic rst_n;

  fmlf_ord_if ord_bus ();
  fmlf_res_if res_bus ();

  filtered_mean_and_lowest_five_core #(
    .KEEP_LOWEST(KEEP),
    .MAX_ORDERS (MAX_ORDERS)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .ord_i (ord_bus),
    .res_o (res_bus)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [31:0]                  tally_sum;
  int unsigned                  tally_count;
  logic [fmlf_pkg::PRICE_W-1:0] low_prices [KEEP];
  int unsigned                  low_count;

  summary_t    pending_summaries [$];
  plan_row_t   plan [$];
  int unsigned mismatches;
  int unsigned summaries_checked;
  int unsigned orders_sent;
  int unsigned qualifying_sent;
  int unsigned burst_left;
  bit          hold_req;

  task automatic clear_tally();
    tally_sum   = '0;
    tally_count = 0;
    low_count   = 0;
    foreach (low_prices[i]) low_prices[i] = '0;
  endtask

  task automatic tally_order(input order_t o, output bit closed, output summary_t s);
    logic [39:0]                  mean;
    logic [fmlf_pkg::PRICE_W-1:0] slot [fmlf_pkg::OUT_SLOTS];
    int unsigned                  pos;
    int unsigned                  shown;
    bit                           take;
    closed = 1'b0;
    s = '0;
    if (o.seller_online && o.is_sell_order) begin
      if (tally_count < MAX_ORDERS) begin
        tally_sum += o.price;
        tally_count++;
      end
      take = 1'b1;
      pos = 0;
      if (low_count < KEEP) begin
        pos = low_count;
        low_count++;
      end else if (o.price < low_prices[KEEP-1]) begin
        pos = KEEP - 1;
      end else begin
        take = 1'b0;
      end
      if (take) begin
        while (pos > 0 && low_prices[pos-1] > o.price) begin
          low_prices[pos] = low_prices[pos-1];
          pos--;
        end
        low_prices[pos] = o.price;
      end
    end
    if (o.last_order) begin
      closed = 1'b1;
      mean = '0;
      if (tally_count != 0) mean = ({8'd0, tally_sum} << 8) / tally_count;
      shown = (low_count < fmlf_pkg::OUT_SLOTS) ? low_count : fmlf_pkg::OUT_SLOTS;
      for (int i = 0; i < fmlf_pkg::OUT_SLOTS; i++)
        slot[i] = (i < shown) ? low_prices[i] : '0;
      s.mean_whole       = mean[23:8];
      s.mean_fraction    = mean[7:0];
      s.lowest_first     = slot[0];
      s.lowest_second    = slot[1];
      s.lowest_third     = slot[2];
      s.lowest_fourth    = slot[3];
      s.lowest_fifth     = slot[4];
      s.lowest_valid     = shown[fmlf_pkg::VALID_W-1:0];
      s.qualifying_count = tally_count[fmlf_pkg::QCOUNT_W-1:0];
      clear_tally();
    end
  endtask

  // Offers one item, waits for acceptance, then updates the prediction.
  task automatic send_order(input order_t o, input bit typed, input summary_t typed_sum);
    int unsigned gap;
    bit          closed;
    summary_t    s;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        ord_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    ord_bus.valid         <= 1'b1;
    ord_bus.price         <= o.price;
    ord_bus.seller_online <= o.seller_online;
    ord_bus.is_sell_order <= o.is_sell_order;
    ord_bus.last_order    <= o.last_order;
    @(posedge clk);
    while (!ord_bus.ready) @(posedge clk);
    burst_left--;
    orders_sent++;
    if (o.seller_online && o.is_sell_order) qualifying_sent++;
    tally_order(o, closed, s);
    if (closed)
      pending_summaries.insert(pending_summaries.size(), typed ? typed_sum : s);
  endtask

  function automatic order_t make_order(logic [fmlf_pkg::PRICE_W-1:0] price, bit online,
                                        bit sell, bit last);
    order_t o;
    o.price         = price;
    o.seller_online = online;
    o.is_sell_order = sell;
    o.last_order    = last;
    return o;
  endfunction

  function automatic void add_row(logic [fmlf_pkg::PRICE_W-1:0] price, bit online, bit sell,
                                  bit last);
    plan_row_t r;
    r.ord     = make_order(price, online, sell, last);
    r.typed   = 1'b0;
    r.summary = '0;
    plan.insert(plan.size(), r);
  endfunction

  function automatic void add_typed(logic [fmlf_pkg::PRICE_W-1:0] price, bit online,
                                    bit sell, bit last, summary_t s);
    plan_row_t r;
    r.ord     = make_order(price, online, sell, last);
    r.typed   = 1'b1;
    r.summary = s;
    plan.insert(plan.size(), r);
  endfunction

  function automatic logic [fmlf_pkg::PRICE_W-1:0] pick_price(int unsigned mode);
    case (mode)
      0: return 16'($urandom_range(0, 65535));
      1: return 16'($urandom_range(0, 15));
      2: begin
        case ($urandom_range(0, 3))
          0: return 16'h0000;
          1: return 16'h0001;
          2: return 16'hFFFE;
          default: return 16'hFFFF;
        endcase
      end
      default: return 16'($urandom_range(1000, 1100));
    endcase
  endfunction

  task automatic send_random_list(output int unsigned sent);
    int unsigned len;
    int unsigned qual_pct;
    int unsigned price_mode;
    int unsigned combo;
    order_t      o;
    summary_t    unused;
    bit          online;
    bit          sell;
    len = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
    case ($urandom_range(0, 5))
      0:       qual_pct = 0;
      1:       qual_pct = 25;
      2:       qual_pct = 100;
      default: qual_pct = 75;
    endcase
    price_mode = $urandom_range(0, 3);
    unused = '0;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < qual_pct) begin
        online = 1'b1;
        sell   = 1'b1;
      end else begin
        combo  = $urandom_range(0, 2);
        online = (combo == 2);
        sell   = (combo == 1);
      end
      o = make_order(pick_price(price_mode), online, sell, i == len - 1);
      send_order(o, 1'b0, unused);
    end
    sent = len;
  endtask

  function automatic void check_field(string name, int unsigned expv, int unsigned actv);
    if (expv != actv) begin
      $error("%s: expected %0d, got %0d", name, expv, actv);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    summary_t e;
    if (rst_n && res_bus.valid && res_bus.ready) begin
      if (pending_summaries.size() == 0) begin
        $error("result with no expectation pending");
        mismatches++;
      end else begin
        e = pending_summaries.pop_front();
        check_field("mean_whole", e.mean_whole, res_bus.mean_whole);
        check_field("mean_fraction", e.mean_fraction, res_bus.mean_fraction);
        check_field("lowest_first", e.lowest_first, res_bus.lowest_first);
        check_field("lowest_second", e.lowest_second, res_bus.lowest_second);
        check_field("lowest_third", e.lowest_third, res_bus.lowest_third);
        check_field("lowest_fourth", e.lowest_fourth, res_bus.lowest_fourth);
        check_field("lowest_fifth", e.lowest_fifth, res_bus.lowest_fifth);
        check_field("lowest_valid", e.lowest_valid, res_bus.lowest_valid);
        check_field("qualifying_count", e.qualifying_count, res_bus.qualifying_count);
        summaries_checked++;
      end
    end
  end

  // receiver: windows of always-ready, random and sparse ready, plus one long hold
  initial begin
    int unsigned mode;
    int unsigned win;
    mode = 0;
    win  = 0;
    res_bus.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        res_bus.ready <= 1'b0;
        for (int n = 0; n < HOLD_LEN; n++) @(posedge clk);
      end
      if (win == 0) begin
        mode = $urandom_range(0, 2);
        win  = $urandom_range(10, 80);
      end
      win--;
      case (mode)
        0:       res_bus.ready <= 1'b1;
        1:       res_bus.ready <= 1'($urandom_range(0, 1));
        default: res_bus.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    summary_t    z;
    summary_t    t;
    int unsigned rand_sent;
    int unsigned n;
    mismatches        = 0;
    summaries_checked = 0;
    orders_sent       = 0;
    qualifying_sent   = 0;
    burst_left        = 0;
    hold_req          = 1'b0;
    clear_tally();
    rst_n                 <= 1'b0;
    ord_bus.valid         <= 1'b0;
    ord_bus.price         <= '0;
    ord_bus.seller_online <= 1'b0;
    ord_bus.is_sell_order <= 1'b0;
    ord_bus.last_order    <= 1'b0;

    // directed part
    z = '0;
    add_typed(16'hFFFF, 1'b0, 1'b1, 1'b1, z);
    add_typed(16'h1234, 1'b1, 1'b0, 1'b1, z);
    add_typed(16'h0000, 1'b0, 1'b0, 1'b1, z);
    t = '0;
    t.lowest_valid     = 3'd1;
    t.qualifying_count = 13'd1;
    add_typed(16'h0000, 1'b1, 1'b1, 1'b1, t);
    t.mean_whole   = 16'hFFFF;
    t.lowest_first = 16'hFFFF;
    add_typed(16'hFFFF, 1'b1, 1'b1, 1'b1, t);
    add_row(16'd1, 1'b1, 1'b1, 1'b0);
    t = '0;
    t.mean_whole       = 16'd1;
    t.mean_fraction    = 8'd128;
    t.lowest_first     = 16'd1;
    t.lowest_second    = 16'd2;
    t.lowest_valid     = 3'd2;
    t.qualifying_count = 13'd2;
    add_typed(16'd2, 1'b1, 1'b1, 1'b1, t);
    add_row(16'd0, 1'b1, 1'b1, 1'b0);
    add_row(16'd0, 1'b1, 1'b1, 1'b0);
    add_row(16'd1, 1'b1, 1'b1, 1'b1);
    // full kept set with repeated prices and a non-qualifying low price
    add_row(16'd50, 1'b1, 1'b1, 1'b0);
    add_row(16'd40, 1'b1, 1'b1, 1'b0);
    add_row(16'd40, 1'b1, 1'b1, 1'b0);
    add_row(16'd5, 1'b1, 1'b0, 1'b0);
    add_row(16'd30, 1'b1, 1'b1, 1'b0);
    add_row(16'd60, 1'b1, 1'b1, 1'b0);
    add_row(16'd10, 1'b1, 1'b1, 1'b0);
    add_row(16'd40, 1'b1, 1'b1, 1'b0);
    add_row(16'd40, 1'b1, 1'b1, 1'b1);
    add_row(16'd9999, 1'b1, 1'b0, 1'b0);
    add_row(16'd8, 1'b0, 1'b1, 1'b0);
    add_typed(16'd7, 1'b0, 1'b0, 1'b1, z);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) send_order(plan[i].ord, plan[i].typed, plan[i].summary);

    // random lists; the receiver holds off early so the block backs up
    hold_req = 1'b1;
    n = 0;
    while (n < RAND_ITEMS) begin
      send_random_list(rand_sent);
      n += rand_sent;
    end
    ord_bus.valid <= 1'b0;

    while (pending_summaries.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Sent %0d orders (%0d qualifying), %0d list summaries checked,",
             orders_sent, qualifying_sent, summaries_checked);
    $display("including empty lists, extreme prices and full kept sets.");
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
